/* rtl/core/assert_macros.svh */
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the rc4 block
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define RC4_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rc4 assertion failed");

// checked at every edge, reset included
`define RC4_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("rc4 assertion failed");

`endif

/* rtl/core/rc4_pkg.sv */
// ---------------------------------------------------------------------------
// rc4 package
// shared constants, state encoding and interface structs of the rc4 block
// ---------------------------------------------------------------------------
package rc4_pkg;

    localparam int BYTE_W      = 8;
    localparam int SBOX_DEPTH  = 256;
    localparam int KEY_MAX_DEF = 256;

    localparam logic CMD_KEY  = 1'b0;
    localparam logic CMD_DATA = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_K_RD_I,
        ST_K_RD_J,
        ST_K_WR_I,
        ST_K_WR_J,
        ST_D_RD_J,
        ST_D_WR_I,
        ST_D_WR_J,
        ST_D_KS,
        ST_D_PASS
    } state_t;

    typedef struct packed {
        logic              cmd;
        logic [BYTE_W-1:0] data_byte;
        logic              last_key;
    } in_req_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              unkeyed;
    } result_t;

    typedef struct packed {
        logic              we;
        logic [BYTE_W-1:0] waddr;
        logic [BYTE_W-1:0] wdata;
        logic              re;
        logic [BYTE_W-1:0] raddr;
    } sbox_req_t;

endpackage

/* rtl/core/rc4_sbox_ram.sv */
// ---------------------------------------------------------------------------
// rc4 s-box memory
// 256 x 8 memory, one write and one registered read port
// ---------------------------------------------------------------------------
module rc4_sbox_ram (
    input  logic                                aclk,
    input  rc4_pkg::sbox_req_t                  req,
    output logic [rc4_pkg::BYTE_W-1:0]          rdata
);
    import rc4_pkg::*;

    logic [BYTE_W-1:0] mem [SBOX_DEPTH];
    logic [BYTE_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re) begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/rc4_key_ram.sv */
// ---------------------------------------------------------------------------
// rc4 key memory
// key byte store, one write and one registered read port
// ---------------------------------------------------------------------------
module rc4_key_ram #(
    parameter int KEY_MAX = rc4_pkg::KEY_MAX_DEF,
    parameter int ADDR_W  = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1
) (
    input  logic                           aclk,
    input  logic                           we,
    input  logic [ADDR_W-1:0]              waddr,
    input  logic [rc4_pkg::BYTE_W-1:0]     wdata,
    input  logic                           re,
    input  logic [ADDR_W-1:0]              raddr,
    output logic [rc4_pkg::BYTE_W-1:0]     rdata
);
    import rc4_pkg::*;

    logic [BYTE_W-1:0] mem [KEY_MAX];
    logic [BYTE_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/rc4_engine.sv */
// ---------------------------------------------------------------------------
// rc4 engine
// sequencer for key storage, key scheduling and keystream generation
// ---------------------------------------------------------------------------
module rc4_engine #(
    parameter int KEY_MAX = rc4_pkg::KEY_MAX_DEF,
    parameter int KIDX_W  = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  rc4_pkg::in_req_t               in_req,
    input  logic                           out_free,
    output logic                           res_valid,
    output rc4_pkg::result_t               res,
    output rc4_pkg::sbox_req_t             sbox_req,
    input  logic [rc4_pkg::BYTE_W-1:0]     sbox_rdata,
    output logic                           key_we,
    output logic [KIDX_W-1:0]              key_waddr,
    output logic [rc4_pkg::BYTE_W-1:0]     key_wdata,
    output logic                           key_re,
    output logic [KIDX_W-1:0]              key_raddr,
    input  logic [rc4_pkg::BYTE_W-1:0]     key_rdata
);
    import rc4_pkg::*;

    localparam int CNT_W = $clog2(KEY_MAX + 1);
    localparam logic [CNT_W-1:0] KEY_MAX_C = CNT_W'(KEY_MAX);
    localparam logic [BYTE_W-1:0] LAST_IDX = BYTE_W'(SBOX_DEPTH - 1);

    state_t            state_reg, state_next;
    logic [BYTE_W-1:0] i_reg, i_next;
    logic [BYTE_W-1:0] j_reg, j_next;
    logic [KIDX_W-1:0] kidx_reg, kidx_next;
    logic [CNT_W-1:0]  key_count_reg, key_count_next;
    logic              keyed_reg, keyed_next;
    logic [BYTE_W-1:0] byte_reg, byte_next;
    logic [BYTE_W-1:0] si_reg, si_next;
    logic [BYTE_W-1:0] t_reg, t_next;
    logic              fwd_reg, fwd_next;
    logic [CNT_W-1:0]  len_m1;
    logic [BYTE_W-1:0] j_new;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            i_reg         <= '0;
            j_reg         <= '0;
            key_count_reg <= '0;
            keyed_reg     <= 1'b0;
        end else begin
            state_reg     <= state_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            key_count_reg <= key_count_next;
            keyed_reg     <= keyed_next;
        end
    end

    always_ff @(posedge aclk) begin
        kidx_reg <= kidx_next;
        byte_reg <= byte_next;
        si_reg   <= si_next;
        t_reg    <= t_next;
        fwd_reg  <= fwd_next;
    end

    assign len_m1 = (key_count_reg == '0) ? '0 : key_count_reg - CNT_W'(1);

    always_comb begin
        state_next     = state_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        kidx_next      = kidx_reg;
        key_count_next = key_count_reg;
        keyed_next     = keyed_reg;
        byte_next      = byte_reg;
        si_next        = si_reg;
        t_next         = t_reg;
        fwd_next       = fwd_reg;
        j_new          = j_reg;
        sbox_req       = '0;
        key_we         = 1'b0;
        key_waddr      = key_count_reg[KIDX_W-1:0];
        key_wdata      = in_req.data_byte;
        key_re         = 1'b0;
        key_raddr      = kidx_reg;
        res_valid      = 1'b0;
        res.out_byte   = byte_reg;
        res.unkeyed    = 1'b1;
        in_ready       = (state_reg == ST_IDLE);

        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    byte_next = in_req.data_byte;
                    if (in_req.cmd == CMD_KEY) begin
                        if (key_count_reg < KEY_MAX_C) begin
                            key_we         = 1'b1;
                            key_count_next = key_count_reg + CNT_W'(1);
                        end
                        if (in_req.last_key) begin
                            i_next     = '0;
                            j_next     = '0;
                            state_next = ST_INIT;
                        end
                    end else if (keyed_reg) begin
                        i_next         = i_reg + BYTE_W'(1);
                        sbox_req.re    = 1'b1;
                        sbox_req.raddr = i_reg + BYTE_W'(1);
                        state_next     = ST_D_RD_J;
                    end else begin
                        state_next = ST_D_PASS;
                    end
                end
            end
            ST_INIT: begin
                sbox_req.we    = 1'b1;
                sbox_req.waddr = i_reg;
                sbox_req.wdata = i_reg;
                i_next         = i_reg + BYTE_W'(1);
                if (i_reg == LAST_IDX) begin
                    kidx_next  = '0;
                    state_next = ST_K_RD_I;
                end
            end
            ST_K_RD_I: begin
                sbox_req.re    = 1'b1;
                sbox_req.raddr = i_reg;
                key_re         = 1'b1;
                state_next     = ST_K_RD_J;
            end
            ST_K_RD_J: begin
                j_new          = j_reg + sbox_rdata + key_rdata;
                j_next         = j_new;
                si_next        = sbox_rdata;
                sbox_req.re    = 1'b1;
                sbox_req.raddr = j_new;
                state_next     = ST_K_WR_I;
            end
            ST_K_WR_I: begin
                sbox_req.we    = 1'b1;
                sbox_req.waddr = i_reg;
                sbox_req.wdata = sbox_rdata;
                state_next     = ST_K_WR_J;
            end
            ST_K_WR_J: begin
                sbox_req.we    = 1'b1;
                sbox_req.waddr = j_reg;
                sbox_req.wdata = si_reg;
                i_next         = i_reg + BYTE_W'(1);
                kidx_next      = (CNT_W'(kidx_reg) == len_m1) ? '0 : kidx_reg + KIDX_W'(1);
                if (i_reg == LAST_IDX) begin
                    j_next         = '0;
                    key_count_next = '0;
                    keyed_next     = 1'b1;
                    state_next     = ST_IDLE;
                end else begin
                    state_next = ST_K_RD_I;
                end
            end
            ST_D_RD_J: begin
                j_new          = j_reg + sbox_rdata;
                j_next         = j_new;
                si_next        = sbox_rdata;
                sbox_req.re    = 1'b1;
                sbox_req.raddr = j_new;
                state_next     = ST_D_WR_I;
            end
            ST_D_WR_I: begin
                sbox_req.we    = 1'b1;
                sbox_req.waddr = i_reg;
                sbox_req.wdata = sbox_rdata;
                t_next         = si_reg + sbox_rdata;
                state_next     = ST_D_WR_J;
            end
            ST_D_WR_J: begin
                // keystream read overlaps the second swap write
                sbox_req.we    = 1'b1;
                sbox_req.waddr = j_reg;
                sbox_req.wdata = si_reg;
                sbox_req.re    = 1'b1;
                sbox_req.raddr = t_reg;
                fwd_next       = (t_reg == j_reg);
                state_next     = ST_D_KS;
            end
            ST_D_KS: begin
                if (out_free) begin
                    res_valid    = 1'b1;
                    res.out_byte = byte_reg ^ (fwd_reg ? si_reg : sbox_rdata);
                    res.unkeyed  = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            ST_D_PASS: begin
                if (out_free) begin
                    res_valid  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/core/rc4_stream_cipher.sv */
// keyed data passes D_RD_J, D_WR_I, D_WR_J, D_KS; unkeyed data passes D_PASS
// requests are taken only in idle; keyed data is paced by the s-box swaps
// a last key byte runs scheduling: s-box init, then K_RD_I to K_WR_J per entry
// reset clears generator indices, key count, keyed flag, valid of output stage
// s-box and key memories are not cleared by reset
// ---------------------------------------------------------------------------
// rc4 stream cipher
// stream wrapper with key store, s-box memory and registered output stage
// ---------------------------------------------------------------------------
module rc4_stream_cipher #(
    parameter int KEY_MAX = rc4_pkg::KEY_MAX_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [rc4_pkg::BYTE_W-1:0]     s_tdata,   // [7:0] data_byte
    input  logic                           s_tuser,   // [0] cmd
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [rc4_pkg::BYTE_W-1:0]     m_tdata,   // [7:0] out_byte
    output logic                           m_tuser    // [0] unkeyed
);
    import rc4_pkg::*;

    localparam int KIDX_W = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;

    in_req_t           in_req;
    result_t           res;
    logic              res_valid;
    logic              out_free;
    sbox_req_t         sbox_req;
    logic [BYTE_W-1:0] sbox_rdata;
    logic              key_we;
    logic              key_re;
    logic [KIDX_W-1:0] key_waddr;
    logic [KIDX_W-1:0] key_raddr;
    logic [BYTE_W-1:0] key_wdata;
    logic [BYTE_W-1:0] key_rdata;

    logic              m_tvalid_reg;
    logic [BYTE_W-1:0] m_tdata_reg;
    logic              m_tuser_reg;

    assign in_req.cmd       = s_tuser;
    assign in_req.data_byte = s_tdata;
    assign in_req.last_key  = s_tlast;

    assign out_free = !m_tvalid_reg || m_tready;

    rc4_engine #(
        .KEY_MAX (KEY_MAX),
        .KIDX_W  (KIDX_W)
    ) u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_req     (in_req),
        .out_free   (out_free),
        .res_valid  (res_valid),
        .res        (res),
        .sbox_req   (sbox_req),
        .sbox_rdata (sbox_rdata),
        .key_we     (key_we),
        .key_waddr  (key_waddr),
        .key_wdata  (key_wdata),
        .key_re     (key_re),
        .key_raddr  (key_raddr),
        .key_rdata  (key_rdata)
    );

    rc4_sbox_ram u_sbox (
        .aclk  (aclk),
        .req   (sbox_req),
        .rdata (sbox_rdata)
    );

    rc4_key_ram #(
        .KEY_MAX (KEY_MAX),
        .ADDR_W  (KIDX_W)
    ) u_key (
        .aclk  (aclk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (key_wdata),
        .re    (key_re),
        .raddr (key_raddr),
        .rdata (key_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_valid) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            m_tdata_reg <= res.out_byte;
            m_tuser_reg <= res.unkeyed;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

/* rtl/core/rc4_checker.sv */
// ---------------------------------------------------------------------------
// rc4 port checker
// port-level assertions for the rc4 stream cipher, bound to the top level
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rc4_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       s_tuser,
    input logic       s_tlast,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tuser
);

    property p_out_hold;
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser);
    endproperty

    // stalled result holds
    `RC4_ASSERT(a_out_hold, aclk, aresetn, p_out_hold)

    // out of reset: idle and empty
    `RC4_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> !m_tvalid && s_tready)

    // key request never produces a result
    `RC4_ASSERT(a_key_no_result, aclk, aresetn, s_tvalid && s_tready && !s_tuser |=> !$rose(m_tvalid))

    // data request or last key byte keeps the block busy
    `RC4_ASSERT(a_busy_after, aclk, aresetn, s_tvalid && s_tready && (s_tuser || s_tlast) |=> !s_tready)

endmodule

bind rc4_stream_cipher rc4_checker u_checker (.*);

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// rc4 stream cipher testbench
// streams key and data requests into the cipher with random gaps on both
// sides, keeps its own copy of the s-box, key store and generator indices
// to work out each output byte, and compares results in arrival order
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rc4_pkg::*;

    localparam int REQ_TOTAL     = 1450;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_AT       = 250;
    localparam int HOLD_CYCLES   = 600;
    localparam int S_CALM_LO     = 600;
    localparam int S_CALM_HI     = 850;
    localparam int M_CALM_LO     = 500;
    localparam int M_CALM_HI     = 650;
    localparam int MAX_REPORTS   = 100;

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [BYTE_W-1:0] s_tdata  = '0;
    logic              s_tuser  = 1'b0;
    logic              s_tlast  = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [BYTE_W-1:0] m_tdata;
    logic              m_tuser;

    rc4_stream_cipher dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    in_req_t     queued_reqs[$];
    result_t     awaited_bytes[$];
    in_req_t     offered_req;

    logic [7:0]  sbox_copy [SBOX_DEPTH];
    logic [7:0]  key_copy  [KEY_MAX_DEF];
    int unsigned key_fill;
    logic [7:0]  idx_i;
    logic [7:0]  idx_j;
    bit          have_key;

    int unsigned reqs_taken;
    int unsigned errors;
    int unsigned cycles;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
    end

    task automatic advance_cipher(input in_req_t req);
        logic [7:0]  t;
        logic [7:0]  jk;
        logic [7:0]  ks;
        int unsigned n;
        if (req.cmd == CMD_KEY) begin
            if (key_fill < KEY_MAX_DEF) begin
                key_copy[key_fill] = req.data_byte;
                key_fill++;
            end
            if (req.last_key) begin
                n = key_fill;
                for (int k = 0; k < SBOX_DEPTH; k++) sbox_copy[k] = 8'(k);
                jk = '0;
                for (int k = 0; k < SBOX_DEPTH; k++) begin
                    jk = jk + sbox_copy[k] + key_copy[k % n];
                    t = sbox_copy[k];
                    sbox_copy[k] = sbox_copy[jk];
                    sbox_copy[jk] = t;
                end
                idx_i    = '0;
                idx_j    = '0;
                key_fill = 0;
                have_key = 1'b1;
            end
        end else if (!have_key) begin
            awaited_bytes.push_back('{out_byte: req.data_byte, unkeyed: 1'b1});
        end else begin
            idx_i = idx_i + 8'd1;
            idx_j = idx_j + sbox_copy[idx_i];
            t = sbox_copy[idx_i];
            sbox_copy[idx_i] = sbox_copy[idx_j];
            sbox_copy[idx_j] = t;
            ks = sbox_copy[8'(sbox_copy[idx_i] + sbox_copy[idx_j])];
            awaited_bytes.push_back('{out_byte: req.data_byte ^ ks, unkeyed: 1'b0});
        end
    endtask

    always @(posedge aclk) begin : drive
        bit idle_now;
        idle_now = !(reqs_taken >= S_CALM_LO && reqs_taken < S_CALM_HI)
                   && ($urandom_range(99) < 21);
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                advance_cipher(offered_req);
                reqs_taken++;
            end
            if (!s_tvalid || s_tready) begin
                if (queued_reqs.size() > 0 && !idle_now) begin
                    offered_req = queued_reqs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= offered_req.data_byte;
                    s_tuser  <= offered_req.cmd;
                    s_tlast  <= offered_req.last_key;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : sink
        int unsigned taken;
        int unsigned hold_left;
        bit          hold_done;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) taken++;
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (!hold_done && taken >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                m_tready <= 1'b0;
            end else if (taken >= M_CALM_LO && taken < M_CALM_HI) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(99) >= 21);
            end
        end
    end

    always @(posedge aclk) begin : watch
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (awaited_bytes.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected result, expected none, actual out_byte %02h unkeyed %0b",
                             $time, m_tdata, m_tuser);
            end else begin
                want = awaited_bytes.pop_front();
                if (m_tdata !== want.out_byte) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: out_byte expected %02h actual %02h",
                                 $time, want.out_byte, m_tdata);
                end
                if (m_tuser !== want.unkeyed) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: unkeyed expected %0b actual %0b",
                                 $time, want.unkeyed, m_tuser);
                end
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results still awaited", $time, awaited_bytes.size());
            $display("FAIL");
            $finish;
        end
    end

    function automatic void queue_req(logic c, logic [7:0] b, logic l);
        queued_reqs.push_back('{cmd: c, data_byte: b, last_key: l});
    endfunction

    task automatic wait_drained();
        while (queued_reqs.size() != 0 || s_tvalid || awaited_bytes.size() != 0)
            @(negedge aclk);
    endtask

    initial begin : stimulus
        int unsigned queued;
        int unsigned seq;
        int unsigned klen;
        int unsigned nd;
        bit          open_key;

        // data before any key, last flag on data ignored
        queue_req(CMD_DATA, 8'h00, 1'b0);
        queue_req(CMD_DATA, 8'hff, 1'b0);
        queue_req(CMD_DATA, 8'ha5, 1'b1);
        // single zero key byte
        queue_req(CMD_KEY,  8'h00, 1'b1);
        queue_req(CMD_DATA, 8'h00, 1'b0);
        queue_req(CMD_DATA, 8'hff, 1'b0);
        queue_req(CMD_DATA, 8'h5a, 1'b1);
        // new key stored while the old one keeps running
        queue_req(CMD_KEY,  8'hff, 1'b0);
        queue_req(CMD_KEY,  8'h00, 1'b0);
        queue_req(CMD_KEY,  8'h80, 1'b0);
        queue_req(CMD_DATA, 8'h11, 1'b0);
        queue_req(CMD_KEY,  8'h01, 1'b1);
        queue_req(CMD_DATA, 8'h00, 1'b0);
        queue_req(CMD_DATA, 8'hff, 1'b0);
        queue_req(CMD_DATA, 8'h3c, 1'b0);
        queued = 15;

        wait_drained();

        seq = 0;
        while (queued < REQ_TOTAL) begin
            if (seq == 2)
                klen = KEY_MAX_DEF + $urandom_range(1, 12);
            else if (seq == 5)
                klen = KEY_MAX_DEF;
            else if ($urandom_range(9) == 0)
                klen = $urandom_range(17, 80);
            else
                klen = $urandom_range(1, 16);
            open_key = (seq > 6) && ($urandom_range(7) == 0);
            for (int k = 0; k < klen; k++) begin
                if (k + 1 < klen && $urandom_range(15) == 0) begin
                    queue_req(CMD_DATA, 8'($urandom), 1'($urandom));
                    queued++;
                end
                queue_req(CMD_KEY, 8'($urandom), (k + 1 == klen) && !open_key);
                queued++;
            end
            nd = $urandom_range(5, 60);
            for (int k = 0; k < nd; k++) begin
                queue_req(CMD_DATA, 8'($urandom), $urandom_range(19) == 0);
                queued++;
            end
            seq++;
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
